@@ hw/rtl/rpn_pkg.sv @@
// Shared types, codes and constants for the RPN stack calculator.
package rpn_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int CMD_W = 3;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W = 7;
  localparam int DEFAULT_STACK_DEPTH = 64;

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

  typedef enum logic [1:0] {
    SEL_ADD,
    SEL_SUB,
    SEL_MUL,
    SEL_DIV
  } op_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic    push;    // write operand on top, count up
    logic    rd;      // read entry below top
    logic    mul_ld;  // register product
    logic    div_go;  // launch divider
    logic    wr;      // write result over a, count down
    op_sel_t sel;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic lt2;
    logic b_zero;
    logic div_done;
  } dp_stat_t;

endpackage

@@ hw/rtl/rpn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/rpn_div.sv @@
// Iterative Q16.16 divider: one quotient bit per cycle, saturating result.
module rpn_div
  import rpn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output logic              done,
  output logic [DATA_W-1:0] quot
);

  // Overflow above this many quotient bits is caught up front.
  localparam int QUO_W = DATA_W + 1;
  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam int HI_W = DATA_W - FRAC_W - 1;

  logic              running;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [QUO_W-1:0]  dq;
  logic [DATA_W-1:0] dvs;
  logic              neg;
  logic              ovf;

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic              big_q;
  logic [QUO_W-1:0]  trial;
  logic [QUO_W-1:0]  diff;
  logic              ge;

  assign mag_a = num[DATA_W-1] ? (~num + 1'b1) : num;
  assign mag_b = den[DATA_W-1] ? (~den + 1'b1) : den;

  // Quotient needs more than QUO_W bits when |a| >= |b| * 2^(QUO_W-FRAC_W).
  assign big_q = (mag_b[DATA_W-1:HI_W] == '0) &&
                 (mag_a >= {mag_b[HI_W-1:0], {(DATA_W-HI_W){1'b0}}});

  assign trial = {rem, dq[QUO_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CNT_W'(QUO_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= {{(DATA_W-HI_W){1'b0}}, mag_a[DATA_W-1:DATA_W-HI_W]};
      dq  <= {mag_a[DATA_W-HI_W-1:0], {FRAC_W{1'b0}}};
      dvs <= mag_b;
      neg <= num[DATA_W-1] ^ den[DATA_W-1];
      ovf <= big_q;
    end else if (running) begin
      rem <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      dq  <= {dq[QUO_W-2:0], ge};
    end
  end

  always_comb begin
    if (ovf) begin
      quot = neg ? Q_MIN : Q_MAX;
    end else if (neg) begin
      quot = (dq > {2'b01, {(QUO_W-2){1'b0}}}) ? Q_MIN : (~dq[DATA_W-1:0] + 1'b1);
    end else begin
      quot = (dq > {1'b0, Q_MAX}) ? Q_MAX : dq[DATA_W-1:0];
    end
  end

endmodule

@@ hw/rtl/rpn_dp.sv @@
// Datapath: stack memory, cached top, depth counter and the arithmetic units.
module rpn_dp
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic signed [DATA_W-1:0] operand,
  output dp_stat_t                 stat,
  output logic signed [DATA_W-1:0] top_value,
  output logic [DEPTH_W-1:0]       stack_depth
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [CW-1:0]            count;
  logic [DATA_W-1:0]        top;
  logic signed [2*DATA_W-1:0] prod;

  logic [CW-1:0]     cnt_m2;
  logic [DATA_W-1:0] a_val;
  logic [DATA_W-1:0] res;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   dif;
  logic [2*DATA_W-1:0] prod_sh;
  logic [DATA_W-1:0] div_q;
  logic              div_done;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;

  function automatic logic [DATA_W-1:0] sat_wide(input logic [2*DATA_W-1:0] v);
    if (v[2*DATA_W-1:DATA_W-1] == {(DATA_W+1){v[2*DATA_W-1]}}) begin
      return v[DATA_W-1:0];
    end
    return v[2*DATA_W-1] ? Q_MIN : Q_MAX;
  endfunction

  assign cnt_m2 = count - CW'(2);

  assign sum     = {a_val[DATA_W-1], a_val} + {top[DATA_W-1], top};
  assign dif     = {a_val[DATA_W-1], a_val} - {top[DATA_W-1], top};
  assign prod_sh = prod >>> FRAC_W;  // floor toward minus infinity

  always_comb begin
    case (cmd.sel)
      SEL_ADD: res = sat_wide({{(DATA_W-1){sum[DATA_W]}}, sum});
      SEL_SUB: res = sat_wide({{(DATA_W-1){dif[DATA_W]}}, dif});
      SEL_MUL: res = sat_wide(prod_sh);
      SEL_DIV: res = div_q;
      default: res = div_q;
    endcase
  end

  assign ram_we    = cmd.push | cmd.wr;
  assign ram_waddr = cmd.push ? count[AW-1:0] : cnt_m2[AW-1:0];
  assign ram_wdata = cmd.push ? operand : res;

  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (a_val)
  );

  rpn_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .num  (a_val),
    .den  (top),
    .done (div_done),
    .quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + 1'b1;
    end else if (cmd.wr) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top <= operand;
    end else if (cmd.wr) begin
      top <= res;
    end
    if (cmd.mul_ld) begin
      prod <= $signed(a_val) * $signed(top);
    end
  end

  assign stat.full     = count == CW'(STACK_DEPTH);
  assign stat.lt2      = count < CW'(2);
  assign stat.b_zero   = top == '0;
  assign stat.div_done = div_done;

  assign top_value   = (count != '0) ? top : '0;
  assign stack_depth = DEPTH_W'(count);

endmodule

@@ hw/rtl/rpn_ctrl.sv @@
// Controller: decodes each command, sequences the datapath, issues the result strobe.
module rpn_ctrl
  import rpn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CMD_W-1:0]    command,
  input  dp_stat_t            stat,
  output dp_cmd_t             cmd,
  output logic                busy,
  output logic                done,
  output logic [STATUS_W-1:0] status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPER,
    S_MULW,
    S_DIVW,
    S_RESP
  } state_t;

  state_t              state;
  state_t              state_next;
  op_sel_t             sel;
  op_sel_t             sel_next;
  logic [STATUS_W-1:0] status_next;

  op_sel_t dec_sel;
  logic    dec_op;

  always_comb begin
    dec_op  = 1'b1;
    dec_sel = SEL_ADD;
    case (command)
      CMD_ADD: dec_sel = SEL_ADD;
      CMD_SUB: dec_sel = SEL_SUB;
      CMD_MUL: dec_sel = SEL_MUL;
      CMD_DIV: dec_sel = SEL_DIV;
      default: dec_op = 1'b0;
    endcase
  end

  always_comb begin
    state_next  = state;
    sel_next    = sel;
    status_next = status;
    cmd         = '0;
    cmd.sel     = sel;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RESP;
          if (command == CMD_PUSH) begin
            if (stat.full) begin
              status_next = ST_OVER;
            end else begin
              status_next = ST_OK;
              cmd.push    = 1'b1;
            end
          end else if (dec_op) begin
            if (stat.lt2) begin
              status_next = ST_UNDER;
            end else begin
              status_next = ST_OK;
              sel_next    = dec_sel;
              cmd.rd      = 1'b1;
              state_next  = S_OPER;
            end
          end else begin
            status_next = ST_INVALID;
          end
        end
      end
      S_OPER: begin
        case (sel)
          SEL_MUL: begin
            cmd.mul_ld = 1'b1;
            state_next = S_MULW;
          end
          SEL_DIV: begin
            if (stat.b_zero) begin
              status_next = ST_DIVZ;
              state_next  = S_RESP;
            end else begin
              cmd.div_go = 1'b1;
              state_next = S_DIVW;
            end
          end
          default: begin
            cmd.wr     = 1'b1;
            state_next = S_RESP;
          end
        endcase
      end
      S_MULW: begin
        cmd.wr     = 1'b1;
        state_next = S_RESP;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.wr     = 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      sel    <= SEL_ADD;
      status <= ST_OK;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      sel    <= sel_next;
      status <= status_next;
      done   <= state_next == S_RESP;
    end
  end

  assign busy = state != S_IDLE;

endmodule

@@ hw/rtl/rpn_stack_calculator_unit.sv @@
// Top level of the RPN stack calculator: controller plus datapath.
//
// A transaction is accepted at a rising edge with start high and busy low;
// command and operand are sampled there. busy stays high until the result
// has been shown, so one transaction is in flight at a time.
// Each transaction gives exactly one result: done is high for one cycle and
// status, top_value and stack_depth are valid in that cycle. The receiver
// cannot stall; the result is taken at the edge that ends the done cycle.
// Controller states from the accepting edge to the done cycle:
//   push, invalid command, or any error caught at decode: S_RESP directly
//   add, subtract, or divide by zero: S_OPER, then S_RESP
//   multiply: S_OPER, S_MULW while the product is registered, then S_RESP
//   divide: S_OPER, S_DIVW until the divider that makes one quotient bit a cycle is done, then S_RESP
// busy drops the cycle after done, so a new transaction may start then.
// The stack sits in a RAM with registered read; the top entry is also held
// in a register. Synchronous reset empties the stack (depth 0) at once;
// the RAM itself is not cleared and needs no clearing pass.
module rpn_stack_calculator_unit
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] operand,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic signed [DATA_W-1:0] top_value,
  output logic [DEPTH_W-1:0]       stack_depth
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rpn_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (dp_stat),
    .cmd     (dp_cmd),
    .busy    (busy),
    .done    (done),
    .status  (status)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .operand     (operand),
    .stat        (dp_stat),
    .top_value   (top_value),
    .stack_depth (stack_depth)
  );

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  a_under_depth: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_UNDER) |-> (stack_depth < DEPTH_W'(2)))
    else $error("underflow reported with two or more entries");

  a_over_depth: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OVER) |-> (stack_depth == DEPTH_W'(STACK_DEPTH)))
    else $error("overflow reported on a stack that is not full");

endmodule

@@ bench/rpn_calc_checker.sv @@
// Checker for the RPN calculator: tracks the stack, predicts each result and compares it.
`timescale 1ns / 1ps

module rpn_calc_checker
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] operand,
  input  logic                     done,
  input  logic [STATUS_W-1:0]      status,
  input  logic signed [DATA_W-1:0] top_value,
  input  logic [DEPTH_W-1:0]       stack_depth,
  output int                       err_count,
  output int                       open_count,
  output int                       result_count
);

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] top;
    logic [DEPTH_W-1:0]       depth;
  } calc_result_t;

  logic signed [DATA_W-1:0] model_stack [STACK_DEPTH];
  int                       model_count;
  calc_result_t             result_queue [$];

  function automatic logic signed [DATA_W-1:0] clamp_q(input longint v);
    if (v > longint'($signed(Q_MAX))) begin
      return Q_MAX;
    end else if (v < longint'($signed(Q_MIN))) begin
      return Q_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  // 64-bit product, arithmetic shift rounds toward minus infinity
  function automatic logic signed [DATA_W-1:0] q_mul(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp_q(p >>> FRAC_W);
  endfunction

  // signed longint division truncates toward zero
  function automatic logic signed [DATA_W-1:0] q_div(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
    longint n;
    n = longint'(a) <<< FRAC_W;
    return clamp_q(n / longint'(b));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic apply_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [DATA_W-1:0] val);
    calc_result_t             r;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] q;
    r.status = ST_OK;
    q = '0;
    if (cmd > CMD_DIV) begin
      r.status = ST_INVALID;
    end else if (cmd == CMD_PUSH) begin
      if (model_count >= STACK_DEPTH) begin
        r.status = ST_OVER;
      end else begin
        model_stack[model_count] = val;
        model_count++;
      end
    end else if (model_count < 2) begin
      r.status = ST_UNDER;
    end else begin
      b = model_stack[model_count-1];
      a = model_stack[model_count-2];
      case (cmd)
        CMD_ADD: q = clamp_q(longint'(a) + longint'(b));
        CMD_SUB: q = clamp_q(longint'(a) - longint'(b));
        CMD_MUL: q = q_mul(a, b);
        default: begin
          if (b == 0) r.status = ST_DIVZ;
          else q = q_div(a, b);
        end
      endcase
      // errors leave both operands in place
      if (r.status == ST_OK) begin
        model_count--;
        model_stack[model_count-1] = q;
      end
    end
    r.top = (model_count > 0) ? model_stack[model_count-1] : '0;
    r.depth = model_count[DEPTH_W-1:0];
    result_queue.push_back(r);
  endtask

  task automatic check_result();
    calc_result_t want;
    if (result_queue.size() == 0) begin
      report_mismatch($sformatf("result with no transaction pending: status %0d top %h depth %0d",
                                status, top_value, stack_depth));
    end else begin
      want = result_queue.pop_front();
      result_count++;
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      if (top_value !== want.top)
        report_mismatch($sformatf("top_value %h, expected %h", top_value, want.top));
      if (stack_depth !== want.depth)
        report_mismatch($sformatf("stack_depth %0d, expected %0d", stack_depth, want.depth));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      model_count = 0;
      result_queue.delete();
      err_count = 0;
      result_count = 0;
    end else begin
      if (done) check_result();
      if (start && !busy) apply_command(command, operand);
    end
    open_count = result_queue.size();
  end

endmodule

@@ bench/tb_rpn_stack_calculator_unit.sv @@
// Testbench top for the RPN calculator: command stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator_unit;
  import rpn_pkg::*;

  localparam int STACK_ENTRIES = DEFAULT_STACK_DEPTH;
  localparam int PHASE_ITEMS = 310;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 45;
  localparam int CMD_TOP = (1 << CMD_W) - 1;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] operand;
  logic                     done;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_W-1:0]       stack_depth;

  int err_count;
  int open_count;
  int result_count;
  int quiet_cycles;
  int idle_pct;
  int calm_left;
  int depth_guess;
  int sent_count;
  int push_count;
  int op_count;
  int bad_count;
  int fill_count;

  rpn_stack_calculator_unit #(
    .STACK_DEPTH(STACK_ENTRIES)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .operand    (operand),
    .done       (done),
    .status     (status),
    .top_value  (top_value),
    .stack_depth(stack_depth)
  );

  rpn_calc_checker #(
    .STACK_DEPTH(STACK_ENTRIES)
  ) calc_chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .operand     (operand),
    .done        (done),
    .status      (status),
    .top_value   (top_value),
    .stack_depth (stack_depth),
    .err_count   (err_count),
    .open_count  (open_count),
    .result_count(result_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // cycles with no transaction in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_operand();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2: v = '0;
      3, 4: v = $urandom();
      default: begin
        // mostly modest values so results stay away from the rails
        v = $urandom_range(0, 32'h0008_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [CMD_W-1:0] pick_operator();
    case ($urandom_range(0, 3))
      0: return CMD_ADD;
      1: return CMD_SUB;
      2: return CMD_MUL;
      default: return CMD_DIV;
    endcase
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val);
    @(negedge clk);
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 30);
    end
    start <= 1'b1;
    command <= cmd;
    operand <= val;
    // busy only moves at the rising edge, so it is stable here
    while (busy) @(negedge clk);
    @(posedge clk);
    sent_count++;
    if (cmd > CMD_DIV) begin
      bad_count++;
    end else if (cmd == CMD_PUSH) begin
      push_count++;
      if (depth_guess < STACK_ENTRIES) depth_guess++;
    end else begin
      op_count++;
      if (depth_guess >= 2) depth_guess--;
    end
  endtask

  task automatic run_random(input int pct);
    int stop_at;
    int fill_at;
    int filled;
    idle_pct = pct;
    stop_at = sent_count + PHASE_ITEMS;
    fill_at = sent_count + $urandom_range(PHASE_ITEMS / 4, PHASE_ITEMS / 2);
    filled = 0;
    while (sent_count < stop_at) begin
      if (!filled && sent_count >= fill_at) begin
        // run the stack into its full limit, then reduce it back down
        repeat (STACK_ENTRIES + 2) send_item(CMD_PUSH, pick_operand());
        repeat (STACK_ENTRIES + 4) send_item(pick_operator(), $urandom());
        filled = 1;
        fill_count++;
      end else begin
        case ($urandom_range(0, 19))
          0: send_item(CMD_W'($urandom_range(int'(CMD_DIV) + 1, CMD_TOP)), $urandom());
          1: send_item(pick_operator(), $urandom());
          default: begin
            if (depth_guess < 2 || (depth_guess < 8 && $urandom_range(0, 1)))
              send_item(CMD_PUSH, pick_operand());
            else
              send_item(pick_operator(), $urandom());
          end
        endcase
      end
    end
  endtask

  initial begin : stim
    int c;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_PUSH;
    operand = '0;
    idle_pct = 32;
    calm_left = 0;
    depth_guess = 0;
    sent_count = 0;
    push_count = 0;
    op_count = 0;
    bad_count = 0;
    fill_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty stack, invalid codes, saturation, rounding, zero divisor
    send_item(CMD_ADD, '0);
    for (c = int'(CMD_DIV) + 1; c <= CMD_TOP; c++) send_item(CMD_W'(c), $urandom());
    send_item(CMD_PUSH, Q_MAX);
    send_item(CMD_SUB, '1);
    send_item(CMD_PUSH, Q_MAX);
    send_item(CMD_ADD, '0);
    send_item(CMD_PUSH, Q_MIN);
    send_item(CMD_SUB, '0);
    send_item(CMD_PUSH, '0);
    send_item(CMD_DIV, '0);
    send_item(CMD_MUL, '0);
    send_item(CMD_PUSH, Q_MIN);
    send_item(CMD_PUSH, 32'shFFFF_0000);
    send_item(CMD_DIV, '1);
    send_item(CMD_PUSH, Q_MIN);
    send_item(CMD_MUL, '0);
    send_item(CMD_PUSH, 32'sd1);
    send_item(CMD_PUSH, -32'sd1);
    send_item(CMD_MUL, '0);
    send_item(CMD_PUSH, 32'sh0003_0000);
    send_item(CMD_DIV, '0);
    send_item(CMD_PUSH, 32'shFFFE_0000);
    send_item(CMD_SUB, '0);
    send_item(CMD_W'(CMD_TOP), Q_MIN);

    run_random(32);
    run_random(47);
    run_random(0);

    @(negedge clk);
    start <= 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d commands: %0d pushes, %0d operators, %0d invalid codes; %0d results compared",
             sent_count, push_count, op_count, bad_count, result_count);
    $display("Stack driven to full %0d times, sender idle at 32, 47 and 0 percent", fill_count);
    if (err_count == 0 && open_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
